/* rtl/bfra_pkg.sv */
`timescale 1ns / 1ps
package bfra_pkg;

  localparam int unsigned AddrW = 20;
  localparam int unsigned LenW  = 21;
  localparam int unsigned RegionLimit = 1048576;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_BAD_SIZE    = 2'd2,
    ST_BAD_POINTER = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  localparam logic [0:0] REG_REGION_SIZE = 1'b0;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  length;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

/* rtl/bfra_if.sv */
`timescale 1ns / 1ps
interface bfra_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bfra_pkg::LenW-1:0]   request_size;
  logic [bfra_pkg::AddrW-1:0]  block_address;
  modport source (output valid, command, request_size, block_address, input ready);
  modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface bfra_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [bfra_pkg::AddrW-1:0]  granted_address;
  modport source (output valid, status, granted_address, input ready);
  modport sink (input valid, status, granted_address, output ready);
endinterface

/* rtl/bfra_cell.sv */
`timescale 1ns / 1ps
// One table slot. Insert/remove are broadcast to every cell; take_new/shift are
// per-cell decisions made by the sequencer. On insert the cell takes either the
// new entry or its left neighbor, on remove it takes its right neighbor.
module bfra_cell (
  input  logic                 clk_i,
  input  bfra_pkg::cell_ctrl_t ctrl_i,
  input  logic                 take_new_i,
  input  logic                 shift_i,
  input  bfra_pkg::entry_t     new_i,
  input  bfra_pkg::entry_t     left_i,
  input  bfra_pkg::entry_t     right_i,
  output bfra_pkg::entry_t     entry_o
);
  bfra_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && take_new_i) begin
      entry_d = new_i;
    end else if (ctrl_i.insert && shift_i) begin
      entry_d = left_i;
    end else if (ctrl_i.remove && shift_i) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule

/* rtl/best_fit_region_allocator.sv */
`timescale 1ns / 1ps
// Steps: the item is taken in S_IDLE, S_SCAN walks the cell chain, S_UPD updates
// the table, then the result waits in S_OUT; bad allocs skip scan and update.
// Throughput: one item at a time; the scan and any output stall set the rate.
// Reset: live count cleared, region_size 65536, no result pending. Table
// contents are not cleared; only entries below the live count are read.
module best_fit_region_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfra_in_if.sink     in_i,
  bfra_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = bfra_pkg::AddrW;
  localparam int unsigned LW = bfra_pkg::LenW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [LW-1:0] region_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic cmd_q;
  logic [AW-1:0] addr_q;
  logic [LW+1:0] need_q;
  logic [LW:0] lo_q, lo_d;
  logic found_q, found_d;
  logic [LW:0] best_gap_q, best_gap_d;
  logic [CntW-1:0] best_idx_q, best_idx_d;
  logic [AW-1:0] best_addr_q, best_addr_d;
  logic [1:0] st_q, st_d;
  logic [AW-1:0] ga_q, ga_d;

  // scan chain: head of an entry copy that shifts toward cell 0 each scan cycle
  bfra_pkg::entry_t cell_out [MAX_BLOCKS];
  bfra_pkg::entry_t scan_q [MAX_BLOCKS];
  bfra_pkg::cell_ctrl_t ctrl;

  assign pready = 1'b1;
  assign prdata = {{(32-LW){1'b0}}, region_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= LW'(65536);
    end else if (psel && penable && pwrite && paddr[2] == bfra_pkg::REG_REGION_SIZE) begin
      region_q <= pwdata[LW-1:0];
    end
  end

  logic [LW:0] rend;
  assign rend = (region_q > LW'(bfra_pkg::RegionLimit)) ?
                (LW+1)'(bfra_pkg::RegionLimit) : {1'b0, region_q};

  bfra_pkg::entry_t head;
  assign head = scan_q[0];
  logic last;
  assign last = (pos_q == count_q);
  logic [LW:0] hi, gap, nxt;
  assign hi  = last ? rend : {1'b0, head.start};
  assign gap = (hi > lo_q) ? hi - lo_q : '0;
  assign nxt = {1'b0, head.start} + {1'b0, head.length};

  logic [LW+1:0] need_c;
  assign need_c = ((({2'b0, in_i.request_size}) + (LW+2)'(ALIGN_BYTES - 1))
                   / (LW+2)'(ALIGN_BYTES)) * (LW+2)'(ALIGN_BYTES)
                  + (LW+2)'(HEADER_BYTES);

  logic hit;
  assign hit = (head.start == addr_q);

  always_comb begin
    state_d = state_q; count_d = count_q; pos_d = pos_q; lo_d = lo_q;
    found_d = found_q; best_gap_d = best_gap_q; best_idx_d = best_idx_q;
    best_addr_d = best_addr_q; st_d = st_q; ga_d = ga_q;
    ctrl = '0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_SCAN; pos_d = '0; lo_d = '0; found_d = 1'b0;
          st_d = bfra_pkg::ST_NO_SPACE; ga_d = '0;
          if (in_i.command == bfra_pkg::CMD_ALLOC) begin
            if (in_i.request_size == '0) begin
              st_d = bfra_pkg::ST_BAD_SIZE; state_d = S_OUT;
            end else if (count_q == CntW'(MAX_BLOCKS)) begin
              state_d = S_OUT;
            end
          end else begin
            st_d = bfra_pkg::ST_BAD_POINTER;
          end
        end
      end
      S_SCAN: begin
        pos_d = pos_q + 1'b1;
        if (cmd_q == bfra_pkg::CMD_ALLOC) begin
          if ({1'b0, gap} >= need_q && (!found_q || gap < best_gap_q)) begin
            found_d = 1'b1; best_gap_d = gap; best_idx_d = pos_q;
            best_addr_d = lo_q[AW-1:0];
          end
          lo_d = nxt;
          if (last) state_d = S_UPD;
        end else begin
          if (last) begin
            state_d = S_OUT;
          end else if (hit) begin
            best_idx_d = pos_q; state_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        state_d = S_OUT;
        if (cmd_q == bfra_pkg::CMD_ALLOC) begin
          if (found_q) begin
            ctrl.insert = 1'b1; count_d = count_q + 1'b1;
            st_d = bfra_pkg::ST_OK; ga_d = best_addr_q;
          end
        end else begin
          ctrl.remove = 1'b1; count_d = count_q - 1'b1; st_d = bfra_pkg::ST_OK;
        end
      end
      S_OUT: begin
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.status = st_q;
  assign out_o.granted_address = ga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; lo_q <= lo_d; found_q <= found_d; best_gap_q <= best_gap_d;
    best_idx_q <= best_idx_d; best_addr_q <= best_addr_d; st_q <= st_d; ga_q <= ga_d;
    if (state_q == S_IDLE && in_i.valid) begin
      cmd_q <= in_i.command;
      addr_q <= in_i.block_address; need_q <= need_c;
    end
  end

  bfra_pkg::entry_t new_entry;
  assign new_entry.start = best_addr_q;
  assign new_entry.length = need_q[LW-1:0];

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    logic take_new, shift;
    bfra_pkg::entry_t lft, rgt;
    assign take_new = (CntW'(g) == best_idx_q);
    assign shift = ctrl.insert ? (CntW'(g) > best_idx_q) : (CntW'(g) >= best_idx_q);
    if (g == 0) begin : g_l
      assign lft = cell_out[0];
    end else begin : g_l
      assign lft = cell_out[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_r
      assign rgt = cell_out[g];
    end else begin : g_r
      assign rgt = cell_out[g+1];
    end
    bfra_cell u_cell (
      .clk_i(clk_i), .ctrl_i(ctrl), .take_new_i(take_new), .shift_i(shift),
      .new_i(new_entry), .left_i(lft), .right_i(rgt), .entry_o(cell_out[g])
    );
    // scan copy: loaded on accept, shifts toward slot 0 during the scan
    if (g == MAX_BLOCKS - 1) begin : g_s
      always_ff @(posedge clk_i) begin
        if (state_q == S_IDLE || state_q == S_SCAN) begin
          scan_q[g] <= cell_out[g];
        end
      end
    end else begin : g_s
      always_ff @(posedge clk_i) begin
        if (state_q == S_IDLE) begin
          scan_q[g] <= cell_out[g];
        end else if (state_q == S_SCAN) begin
          scan_q[g] <= scan_q[g+1];
        end
      end
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BLOCKS)) else $error("live count overflow");
  a_ok_alloc_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && ctrl.insert) |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not bump count");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> pos_q <= count_q) else $error("scan ran past table");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid && $stable(st_q))
    else $error("result dropped");
endmodule
